// ===== rtl/core/rfdkm_pkg.sv =====
// Package for the remote frame decoder with key masking.
// Holds the shared widths, the packed result word and the key unit control struct.
// No dependencies.
package rfdkm_pkg;

	localparam int unsigned FRAME_W = 64;
	localparam int unsigned KEY_W   = 16;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned CH_W    = 11;
	localparam int unsigned IN_W    = 2 * FRAME_W + KEY_W + CNT_W;

	// Item kinds carried on the input tuser bit
	typedef enum logic {
		FUNC_FRAME = 1'b0,
		FUNC_ARM   = 1'b1
	} func_t;

	// Result word, declared from the top bit down so stick_ch1 lands at bit 0
	typedef struct packed {
		logic [KEY_W-1:0]       key_mask;
		logic [7:0]             press_right;
		logic [7:0]             press_left;
		logic signed [15:0]     mouse_z;
		logic signed [15:0]     mouse_y;
		logic signed [15:0]     mouse_x;
		logic [1:0]             switch_right;
		logic [1:0]             switch_left;
		logic signed [CH_W-1:0] stick_ch4;
		logic signed [CH_W-1:0] stick_ch3;
		logic signed [CH_W-1:0] stick_ch2;
		logic signed [CH_W-1:0] stick_ch1;
	} out_word_t;

	localparam int unsigned OUT_W = $bits(out_word_t);

	// Control from the input stage to the key countdown unit
	typedef struct packed {
		logic             arm;
		logic             frame;
		logic [KEY_W-1:0] key_onehot;
		logic [CNT_W-1:0] ticks;
		logic [KEY_W-1:0] keys_raw;
		logic [15:0]      mouse_x;
	} key_ctl_t;

endpackage

// ===== rtl/core/remote_frame_decoder_key_mask.sv =====
// Top level of the remote frame decoder with per-key disable countdowns.
// Depends on rfdkm_pkg, rfdkm_unpack and rfdkm_keymask.
//
//  channel | dir | tdata fields (low bit up)                              | tuser
//  s_*     | in  | frame_low, frame_high, key_onehot, disable_ticks       | func
//  m_*     | out | stick_ch1..4, switch_left/right, mouse_x/y/z,          | -
//          |     | press_left, press_right, key_mask                      |
//
// One input word per cycle while m_tready does not stall; a frame word reaches m_* through the
// input register, then the result register. Arm words give no output word.
// The countdowns and the flag update as a word leaves the input register, so
// words act in arrival order. Reset clears all countdowns and the flag.
// A stalled m_tready holds the result and backs up into the input register.
module remote_frame_decoder_key_mask
	import rfdkm_pkg::*;
#(
	parameter int unsigned NUM_KEYS = 15
)
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,   // frame_low, frame_high, key_onehot, disable_ticks
	input  logic [0:0]      s_tuser,   // func
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OUT_W-1:0] m_tdata   // stick_ch1..4, switches, mouse x/y/z, presses, key_mask
);

	logic            valid_s1;
	func_t           func_s1;
	logic [IN_W-1:0] data_s1;
	logic            m_valid_q;
	out_word_t       out_q;
	logic            adv;
	logic            out_free;
	out_word_t       fields;
	out_word_t       result;
	key_ctl_t        ctl;
	logic [KEY_W-1:0] keys_masked;

	// Arm words retire at once; frame words need room in the result register
	assign out_free = !m_valid_q || m_tready;
	assign adv      = valid_s1 && (func_s1 == FUNC_ARM || out_free);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			func_s1 <= func_t'(s_tuser[0]);
		end
	end

	rfdkm_unpack u_unpack (
		.frame_low  (data_s1[FRAME_W-1:0]),
		.frame_high (data_s1[2*FRAME_W-1:FRAME_W]),
		.fields     (fields)
	);

	// Control to the countdown unit, qualified by the handover
	always_comb begin
		ctl.arm        = adv && func_s1 == FUNC_ARM;
		ctl.frame      = adv && func_s1 == FUNC_FRAME;
		ctl.key_onehot = data_s1[2*FRAME_W+KEY_W-1:2*FRAME_W];
		ctl.ticks      = data_s1[IN_W-1:2*FRAME_W+KEY_W];
		ctl.keys_raw   = fields.key_mask;
		ctl.mouse_x    = fields.mouse_x;
	end

	rfdkm_keymask #(
		.NUM_KEYS (NUM_KEYS)
	) u_keymask (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.keys_masked (keys_masked)
	);

	always_comb begin
		result          = fields;
		result.key_mask = keys_masked;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= ctl.frame;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.frame) begin
			out_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== rtl/core/rfdkm_unpack.sv =====
// Frame field extraction: splits the two 64-bit frame words into the result fields.
// Depends on rfdkm_pkg. Purely combinational; the key mask leaves here unmasked.
module rfdkm_unpack
	import rfdkm_pkg::*;
(
	input  logic [FRAME_W-1:0] frame_low,
	input  logic [FRAME_W-1:0] frame_high,
	output out_word_t          fields
);

	// Sticks: minus 1024 modulo 2^11 is a flip of the top bit
	always_comb begin
		fields.stick_ch1    = frame_low[10:0]  ^ 11'h400;
		fields.stick_ch2    = frame_low[21:11] ^ 11'h400;
		fields.stick_ch3    = frame_low[32:22] ^ 11'h400;
		fields.stick_ch4    = frame_low[43:33] ^ 11'h400;
		// byte 5 holds both switches
		fields.switch_right = frame_low[45:44];
		fields.switch_left  = frame_low[47:46];
		fields.mouse_x      = frame_low[63:48];
		fields.mouse_y      = frame_high[15:0];
		fields.mouse_z      = frame_high[31:16];
		fields.press_left   = frame_high[39:32];
		fields.press_right  = frame_high[47:40];
		fields.key_mask     = frame_high[63:48];
	end

endmodule

// ===== rtl/core/rfdkm_keymask.sv =====
// Per-key disable countdowns and the sticky keyboard-active flag.
// Depends on rfdkm_pkg. Counters update on the cycle the input stage hands over a word.
module rfdkm_keymask
	import rfdkm_pkg::*;
#(
	parameter int unsigned NUM_KEYS = 15
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  key_ctl_t         ctl,
	output logic [KEY_W-1:0] keys_masked
);

	logic [CNT_W-1:0] cnt_q [NUM_KEYS];
	logic [KEY_W-1:0] key_sel;
	logic [KEY_W-1:0] disabled;
	logic             kb_active_q;

	// Highest set bit wins: bit i selected when nothing above it is set
	always_comb begin
		for (int i = 0; i < KEY_W; i++) begin
			key_sel[i] = ((ctl.key_onehot >> i) == KEY_W'(1));
		end
	end

	// One countdown per maskable key; keys at or above NUM_KEYS pass through
	for (genvar g = 0; g < KEY_W; g++) begin : g_key
		if (g < NUM_KEYS) begin : g_cnt
			assign disabled[g] = (cnt_q[g] != '0);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q[g] <= '0;
				end else if (ctl.arm && key_sel[g]) begin
					cnt_q[g] <= ctl.ticks;
				end else if (ctl.frame && disabled[g]) begin
					cnt_q[g] <= cnt_q[g] - CNT_W'(1);
				end
			end
		end else begin : g_none
			assign disabled[g] = 1'b0;
		end
	end

	assign keys_masked = ctl.keys_raw & ~disabled;

	// Sticky flag: any key or mouse x activity on a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kb_active_q <= 1'b0;
		end else if (ctl.frame && (keys_masked != '0 || ctl.mouse_x != '0)) begin
			kb_active_q <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_kb_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		kb_active_q |=> kb_active_q)
		else $error("keyboard active flag dropped");

	a_kb_set: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.frame && ctl.mouse_x != '0) |=> kb_active_q)
		else $error("keyboard active not set by mouse x");

	a_cnt_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.frame && !ctl.arm && cnt_q[0] != '0)
		|=> cnt_q[0] == CNT_W'($past(cnt_q[0]) - CNT_W'(1)))
		else $error("key 0 countdown did not decrement");

	a_cnt_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.arm && key_sel[0]) |=> cnt_q[0] == $past(ctl.ticks))
		else $error("key 0 countdown not loaded on arm");
`endif

endmodule

// ===== dv/remote_frame_decoder_key_mask_tb.sv =====
// Self-checking testbench for remote_frame_decoder_key_mask.
// Predicts each decoded frame, including the key-disable countdowns, and checks m_* words in order.
// Depends on rfdkm_pkg and the RTL of the block; no files are read.
module remote_frame_decoder_key_mask_tb;
	import rfdkm_pkg::*;

	localparam int unsigned NUM_KEYS   = 15;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned MAX_SHOWN  = 10;
	localparam logic [CH_W-1:0] CH_OFFSET = 11'd1024;

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic [0:0]       s_tuser  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// predictor state
	logic [CNT_W-1:0] key_countdown [NUM_KEYS];
	logic             keyboard_active;
	out_word_t        expected_frames [$];

	int unsigned mismatch_count = 0;
	int unsigned idle_cycles    = 0;
	int unsigned burst_left     = 0;

	remote_frame_decoder_key_mask #(
		.NUM_KEYS(NUM_KEYS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// arm a countdown: highest set bit picks the key, keys without a counter are dropped
	function automatic void arm_countdown(logic [KEY_W-1:0] key, logic [CNT_W-1:0] ticks);
		int idx;
		idx = -1;
		for (int b = 0; b < KEY_W; b++)
			if (key[b]) idx = b;
		if (idx >= 0 && idx < NUM_KEYS)
			key_countdown[idx] = ticks;
	endfunction

	// decode one frame and step the countdowns
	function automatic out_word_t decode_frame(logic [63:0] lo, logic [63:0] hi);
		out_word_t        w;
		logic [KEY_W-1:0] masked;
		masked         = '0;
		w.stick_ch1    = lo[10:0] - CH_OFFSET;
		w.stick_ch2    = lo[21:11] - CH_OFFSET;
		w.stick_ch3    = lo[32:22] - CH_OFFSET;
		w.stick_ch4    = lo[43:33] - CH_OFFSET;
		w.switch_left  = lo[47:46];
		w.switch_right = lo[45:44];
		w.mouse_x      = lo[63:48];
		w.mouse_y      = hi[15:0];
		w.mouse_z      = hi[31:16];
		w.press_left   = hi[39:32];
		w.press_right  = hi[47:40];
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (key_countdown[k] != '0) begin
				key_countdown[k] = key_countdown[k] - CNT_W'(1);
				masked[k] = 1'b1;
			end
		end
		w.key_mask = hi[63:48] & ~masked;
		if (w.key_mask != '0 || w.mouse_x != '0)
			keyboard_active = 1'b1;
		return w;
	endfunction

	// drive one word, wait for the handshake, then predict and maybe open a gap
	task automatic send_word(func_t f, logic [63:0] lo, logic [63:0] hi,
			logic [KEY_W-1:0] key, logic [CNT_W-1:0] ticks);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {ticks, key, hi, lo};
		s_tuser  <= f;
		do @(posedge clk); while (!s_tready);
		if (f == FUNC_ARM)
			arm_countdown(key, ticks);
		else
			expected_frames.push_back(decode_frame(lo, hi));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// long unbroken bursts now and then, short ones mostly
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 30);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_frame(logic [63:0] lo, logic [63:0] hi);
		send_word(FUNC_FRAME, lo, hi, KEY_W'($urandom), CNT_W'($urandom));
	endtask

	task automatic send_arm(logic [KEY_W-1:0] key, logic [CNT_W-1:0] ticks);
		send_word(FUNC_ARM, {$urandom, $urandom}, {$urandom, $urandom}, key, ticks);
	endtask

	// field extremes: zero, all ones, channels at the offset, alternating bits
	task automatic test_frame_extremes();
		send_frame(64'h0, 64'h0);
		send_frame('1, '1);
		send_frame({16'h8000, 4'h0, 11'h400, 11'h400, 11'h400, 11'h400},
			{16'h0000, 8'h00, 8'hFF, 16'h7FFF, 16'h8000});
		send_frame({16'h7FFF, 4'hF, 11'h3FF, 11'h3FF, 11'h3FF, 11'h3FF},
			{16'h0000, 8'hFF, 8'h00, 16'h8000, 16'h7FFF});
		send_frame(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_frame(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	// arming: low and high keys, key 15, zero key, several bits, zero ticks clearing
	task automatic test_key_disable();
		send_arm(16'h0001, 16'd2);
		send_arm(16'h4000, 16'd1);
		send_arm(16'h8000, 16'd5);
		send_arm(16'h0000, 16'd7);
		send_arm(16'h0009, 16'd3);
		send_arm(16'h0020, 16'hFFFF);
		send_arm(16'h0020, 16'd0);
		send_frame('1, '1);
		send_frame({$urandom, $urandom}, {16'hFFFF, 16'h0, $urandom});
		send_frame({$urandom, $urandom}, {16'hFFFF, 16'h0, $urandom});
		send_frame({$urandom, $urandom}, {16'hFFFF, 16'h0, $urandom});
		send_arm(16'h0400, 16'd2);
		send_frame(64'h0, {16'h0400, 48'h0});
		send_frame(64'h0, {16'h0400, 48'h0});
		send_frame(64'h0, {16'h0400, 48'h0});
	endtask

	// mixed random traffic, frames weighted with busy key masks
	task automatic test_random_traffic(int unsigned count);
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] ticks;
		logic [63:0]      hi;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) != 0) begin
				hi = {$urandom, $urandom};
				if ($urandom_range(0, 1) == 0)
					hi[63:48] = hi[63:48] | 16'hFFF0;
				send_frame({$urandom, $urandom}, hi);
			end else begin
				case ($urandom_range(0, 9))
					0:       key = '0;
					1, 2:    key = KEY_W'($urandom);
					default: key = 16'h1 << $urandom_range(0, 15);
				endcase
				case ($urandom_range(0, 9))
					0:       ticks = '0;
					1:       ticks = 16'hFFFF;
					2:       ticks = CNT_W'($urandom);
					default: ticks = CNT_W'($urandom_range(1, 8));
				endcase
				send_arm(key, ticks);
			end
		end
	endtask

	// receiver stall pattern: a randomly chosen mode held for a random span, then another
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned phase;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(64, 256);
			repeat (span) begin
				@(posedge clk);
				phase++;
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (phase % 3 == 0);
					default: m_tready <= ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_SHOWN)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	// check every accepted result word against the oldest prediction
	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = out_word_t'(m_tdata);
			if (expected_frames.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN)
					$display("unexpected result word %h", m_tdata);
			end else begin
				want = expected_frames.pop_front();
				report_field("stick_ch1", 16'(want.stick_ch1), 16'(got.stick_ch1));
				report_field("stick_ch2", 16'(want.stick_ch2), 16'(got.stick_ch2));
				report_field("stick_ch3", 16'(want.stick_ch3), 16'(got.stick_ch3));
				report_field("stick_ch4", 16'(want.stick_ch4), 16'(got.stick_ch4));
				report_field("switch_left", 16'(want.switch_left), 16'(got.switch_left));
				report_field("switch_right", 16'(want.switch_right),
					16'(got.switch_right));
				report_field("mouse_x", want.mouse_x, got.mouse_x);
				report_field("mouse_y", want.mouse_y, got.mouse_y);
				report_field("mouse_z", want.mouse_z, got.mouse_z);
				report_field("press_left", 16'(want.press_left), 16'(got.press_left));
				report_field("press_right", 16'(want.press_right), 16'(got.press_right));
				report_field("key_mask", want.key_mask, got.key_mask);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int k = 0; k < NUM_KEYS; k++)
			key_countdown[k] = '0;
		keyboard_active = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_extremes();
		test_key_disable();
		test_random_traffic(1530);

		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== remote_frame_decoder_key_mask.f =====
rtl/core/rfdkm_pkg.sv
rtl/core/rfdkm_unpack.sv
rtl/core/rfdkm_keymask.sv
rtl/core/remote_frame_decoder_key_mask.sv
dv/remote_frame_decoder_key_mask_tb.sv
